[rtl/pol_pkg.sv]
// ----------------------------------------------------------------------------
// pol_pkg: shared types for the positional ordered list
// Command and status codes, cell operations and controller states.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COMMAND_W  = 3;
  localparam int unsigned POSITION_W = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ECOUNT_W   = 5;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_PREV,
    CELL_FROM_NEXT,
    CELL_FROM_FRONT
  } cell_op_t;

  typedef enum logic {
    ST_RUN,
    ST_DUMP
  } state_t;

endpackage

[rtl/pol_if.sv]
// ----------------------------------------------------------------------------
// pol_if: channel interfaces of the positional ordered list
// Command channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pol_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [pol_pkg::COMMAND_W-1:0]  command;
  logic signed [pol_pkg::VALUE_W-1:0]    value;
  logic        [pol_pkg::POSITION_W-1:0] position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface pol_out_if;
  logic                                valid;
  logic                                ready;
  logic        [pol_pkg::STATUS_W-1:0] status;
  logic        [pol_pkg::ECOUNT_W-1:0] entry_count;
  logic signed [pol_pkg::VALUE_W-1:0]  element;
  logic                                last;

  modport source (output valid, status, entry_count, element, last, input ready);
  modport sink   (input valid, status, entry_count, element, last, output ready);
endinterface

[rtl/positional_ordered_list.sv]
// ----------------------------------------------------------------------------
// positional_ordered_list: bounded ordered list in a row of shifting cells
// Inserts and deletes at front, back or a 1-based position; dumps in order.
// ----------------------------------------------------------------------------
// Every insert or delete is taken at once: the cells from its position on
// shift toward the back or the front together, and the single result
// transaction is registered, so edit commands stream at one per cycle while
// the result side keeps up. A dump of N elements holds the command channel:
// after it is taken, each step that the result side allows rotates the first
// N cells by one and sends out the front cell, which leaves the list as it
// was; no command is taken until the last element has been handed over.
// A dump of an empty list and every edit give one result in the next cycle.
// CAPACITY sets the number of cells; entry_count carries the low five bits
// of the element count.
module positional_ordered_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pol_in_if.sink    in_ch,
  pol_out_if.source out_ch
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = CW + 6;

  pol_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   dcnt_r, dcnt_nxt;

  logic                                out_valid_r, out_valid_nxt;
  pol_pkg::status_t                    out_status_r, out_status_nxt;
  logic [CW-1:0]                       out_count_r, out_count_nxt;
  logic signed [pol_pkg::VALUE_W-1:0]  out_element_r, out_element_nxt;
  logic                                out_last_r, out_last_nxt;

  logic signed [pol_pkg::VALUE_W-1:0] cell_data [CAPACITY];
  pol_pkg::cell_op_t                  cell_op   [CAPACITY];

  logic             out_free;
  logic             accept;
  logic             dump_step;
  logic             dump_last;
  logic             dump_start;
  pol_pkg::cmd_t    cmd;
  pol_pkg::status_t edit_status;
  logic             ins_en, del_en;
  logic [CMPW-1:0]  idx;
  logic [CMPW-1:0]  pos_x, cnt_x, last_x;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign accept     = in_ch.valid && in_ch.ready;
  assign cmd        = pol_pkg::cmd_t'(in_ch.command);
  assign pos_x      = CMPW'(in_ch.position);
  assign cnt_x      = CMPW'(count_r);
  assign last_x     = cnt_x - CMPW'(1);
  assign dump_last  = (dcnt_r == count_r - CW'(1));
  assign dump_start = accept && (cmd == pol_pkg::CMD_DUMP) && (count_r != '0);

  // command decode
  always_comb begin
    edit_status = pol_pkg::STAT_OK;
    ins_en      = 1'b0;
    del_en      = 1'b0;
    idx         = '0;
    unique case (cmd)
      pol_pkg::CMD_INS_FRONT, pol_pkg::CMD_INS_BACK, pol_pkg::CMD_INS_AT: begin
        if (cnt_x >= CMPW'(CAPACITY)) begin
          edit_status = pol_pkg::STAT_FULL;
        end else if (cmd == pol_pkg::CMD_INS_FRONT) begin
          ins_en = 1'b1;
        end else if (cmd == pol_pkg::CMD_INS_BACK) begin
          ins_en = 1'b1;
          idx    = cnt_x;
        end else if (pos_x < CMPW'(1) || pos_x > cnt_x + CMPW'(1)) begin
          edit_status = pol_pkg::STAT_INVALID;
        end else begin
          ins_en = 1'b1;
          idx    = pos_x - CMPW'(1);
        end
      end
      pol_pkg::CMD_DEL_FRONT, pol_pkg::CMD_DEL_BACK, pol_pkg::CMD_DEL_AT: begin
        if (count_r == '0) begin
          edit_status = pol_pkg::STAT_EMPTY;
        end else if (cmd == pol_pkg::CMD_DEL_FRONT) begin
          del_en = 1'b1;
        end else if (cmd == pol_pkg::CMD_DEL_BACK) begin
          del_en = 1'b1;
          idx    = last_x;
        end else if (pos_x < CMPW'(1) || pos_x > cnt_x) begin
          edit_status = pol_pkg::STAT_INVALID;
        end else begin
          del_en = 1'b1;
          idx    = pos_x - CMPW'(1);
        end
      end
      pol_pkg::CMD_DUMP: begin
        if (count_r == '0) begin
          edit_status = pol_pkg::STAT_EMPTY;
        end
      end
      default: edit_status = pol_pkg::STAT_INVALID;
    endcase
  end

  // cell row
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [pol_pkg::VALUE_W-1:0] prev_v, next_v;

      if (gi == 0) begin : g_first
        assign prev_v = '0;
      end else begin : g_mid_p
        assign prev_v = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_v = '0;
      end else begin : g_mid_n
        assign next_v = cell_data[gi+1];
      end

      always_comb begin
        cell_op[gi] = pol_pkg::CELL_HOLD;
        if (dump_step) begin
          cell_op[gi] = (CMPW'(gi) == last_x) ? pol_pkg::CELL_FROM_FRONT
                                              : pol_pkg::CELL_FROM_NEXT;
        end else if (accept && ins_en) begin
          if (CMPW'(gi) == idx) begin
            cell_op[gi] = pol_pkg::CELL_LOAD;
          end else if (CMPW'(gi) > idx) begin
            cell_op[gi] = pol_pkg::CELL_FROM_PREV;
          end
        end else if (accept && del_en) begin
          if (CMPW'(gi) >= idx) begin
            cell_op[gi] = pol_pkg::CELL_FROM_NEXT;
          end
        end
      end

      pol_cell u_cell (
        .clk         (clk),
        .op          (cell_op[gi]),
        .new_value   (in_ch.value),
        .prev_value  (prev_v),
        .next_value  (next_v),
        .front_value (cell_data[0]),
        .data        (cell_data[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pol_pkg::ST_RUN:  if (dump_start) state_nxt = pol_pkg::ST_DUMP;
      pol_pkg::ST_DUMP: if (dump_step && dump_last) state_nxt = pol_pkg::ST_RUN;
      default:          state_nxt = pol_pkg::ST_RUN;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    dump_step   = 1'b0;
    unique case (state_r)
      pol_pkg::ST_RUN:  in_ch.ready = out_free;
      pol_pkg::ST_DUMP: dump_step   = out_free;
      default: begin
        in_ch.ready = 1'b0;
        dump_step   = 1'b0;
      end
    endcase
  end

  // count, dump counter and result register
  always_comb begin
    count_nxt       = count_r;
    dcnt_nxt        = dcnt_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      if (ins_en) begin
        count_nxt = count_r + CW'(1);
      end else if (del_en) begin
        count_nxt = count_r - CW'(1);
      end
      dcnt_nxt = '0;
      if (!dump_start) begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = edit_status;
        out_count_nxt   = count_nxt;
        out_element_nxt = '0;
        out_last_nxt    = 1'b1;
      end
    end else if (dump_step) begin
      dcnt_nxt        = dcnt_r + CW'(1);
      out_valid_nxt   = 1'b1;
      out_status_nxt  = pol_pkg::STAT_OK;
      out_count_nxt   = count_r;
      out_element_nxt = cell_data[0];
      out_last_nxt    = dump_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pol_pkg::ST_RUN;
      count_r     <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = pol_pkg::ECOUNT_W'(out_count_r);
  assign out_ch.element     = out_element_r;
  assign out_ch.last        = out_last_r;

endmodule

[rtl/pol_cell.sv]
// ----------------------------------------------------------------------------
// pol_cell: one storage cell of the list row
// Holds one element and loads a new value, a neighbor's value or the front cell's value on command.
// ----------------------------------------------------------------------------
module pol_cell (
  input  logic                               clk,
  input  pol_pkg::cell_op_t                  op,
  input  logic signed [pol_pkg::VALUE_W-1:0] new_value,
  input  logic signed [pol_pkg::VALUE_W-1:0] prev_value,
  input  logic signed [pol_pkg::VALUE_W-1:0] next_value,
  input  logic signed [pol_pkg::VALUE_W-1:0] front_value,
  output logic signed [pol_pkg::VALUE_W-1:0] data
);

  logic signed [pol_pkg::VALUE_W-1:0] data_r;
  logic signed [pol_pkg::VALUE_W-1:0] data_nxt;

  always_comb begin
    unique case (op)
      pol_pkg::CELL_HOLD:       data_nxt = data_r;
      pol_pkg::CELL_LOAD:       data_nxt = new_value;
      pol_pkg::CELL_FROM_PREV:  data_nxt = prev_value;
      pol_pkg::CELL_FROM_NEXT:  data_nxt = next_value;
      pol_pkg::CELL_FROM_FRONT: data_nxt = front_value;
      default:                  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
